[design/f2p_pkg.sv]
// shared types and constants for the float to pcm16 converter
package f2p_pkg;

    localparam logic [15:0] POS_SCALE = 16'd32767;
    localparam logic [16:0] NEG_SCALE = 17'd32768;
    localparam logic [7:0]  EXP_ONE   = 8'd127;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;
    localparam logic [7:0]  SHIFT_BASE = 8'd150;
    localparam logic [7:0]  SHIFT_LIM  = 8'd40;

    // stage one result: decoded operand
    typedef struct packed {
        logic        neg;
        logic        zero;    // nan or shift out of range
        logic        sat;     // magnitude one or more
        logic [23:0] mant;
        logic [5:0]  shift;
        logic [15:0] idx;
        logic        last;
    } f2p_dec_t;

    // stage two result: scaled product
    typedef struct packed {
        logic        neg;
        logic        zero;
        logic        sat;
        logic [39:0] prod;
        logic [5:0]  shift;
        logic [15:0] idx;
        logic        last;
    } f2p_mul_t;

endpackage

[design/float_to_pcm16_clip_top.sv]
// top level of the float32 to pcm16 sample converter
//
// input channel: in_valid/in_ready with mix_sample (ieee single bits),
// sample_index and last_in_run. output channel: out_valid/out_ready with
// pcm_sample, write_index and last_out.
// each word is clamped to -1.0 .. 1.0, scaled by 32767 (positive) or
// 32768 (negative) and truncated toward zero; nan gives 0.
// an accepted word passes three register stages before it is offered at the
// output: decode, 24x17 multiply, shift and sign. throughput is one word per
// cycle while out_ready stays high, set by the three register stages each
// taking a new word every cycle unless the output stalls.
// reset empties the pipeline; out_valid is low after reset.
// when the receiver holds out_ready low, the stages fill and in_ready
// drops only once every stage holds a word; nothing is lost or repeated.
module float_to_pcm16_clip_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        mix_sample,
    input  logic [15:0]        sample_index,
    input  logic               last_in_run,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] pcm_sample,
    output logic [15:0]        write_index,
    output logic               last_out
);
    logic [15:0] pcm_bits;

    f2p_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_bits   (mix_sample),
        .in_idx    (sample_index),
        .in_last   (last_in_run),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pcm   (pcm_bits),
        .out_idx   (write_index),
        .out_last  (last_out)
    );

    assign pcm_sample = signed'(pcm_bits);

endmodule

[design/f2p_pipe.sv]
// three stage conversion datapath with stall-capable valid pipeline
module f2p_pipe (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_bits,
    input  logic [15:0] in_idx,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_pcm,
    output logic [15:0] out_idx,
    output logic        out_last
);
    import f2p_pkg::*;

    logic     v1_reg, v2_reg, v3_reg;
    f2p_dec_t d1_reg, d1_next;
    f2p_mul_t d2_reg, d2_next;
    logic [15:0] pcm3_reg, pcm3_next;
    logic [15:0] idx3_reg;
    logic        last3_reg;
    logic en1, en2, en3;

    logic [7:0]  expo, expo_eff, sh8;
    logic [22:0] frac;
    logic [16:0] scale;
    logic [16:0] scale3;
    logic [16:0] mag;
    logic [39:0] shifted;

    // a stage advances when it is empty or the one after moves
    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        expo     = in_bits[30:23];
        frac     = in_bits[22:0];
        expo_eff = (expo == 8'd0) ? 8'd1 : expo;
        sh8      = SHIFT_BASE - expo_eff;
        d1_next.neg   = in_bits[31];
        d1_next.sat   = (expo >= EXP_ONE) && !(expo == EXP_MAX && frac != 23'd0);
        d1_next.zero  = (expo == EXP_MAX && frac != 23'd0) ||
                        (expo < EXP_ONE && sh8 >= SHIFT_LIM);
        d1_next.mant  = {(expo != 8'd0), frac};
        d1_next.shift = sh8[5:0];
        d1_next.idx   = in_idx;
        d1_next.last  = in_last;
    end

    always_comb
    begin
        scale = d1_reg.neg ? NEG_SCALE : {1'b0, POS_SCALE};
        d2_next.neg   = d1_reg.neg;
        d2_next.zero  = d1_reg.zero;
        d2_next.sat   = d1_reg.sat;
        d2_next.prod  = {16'd0, d1_reg.mant} * {23'd0, scale};
        d2_next.shift = d1_reg.shift;
        d2_next.idx   = d1_reg.idx;
        d2_next.last  = d1_reg.last;
    end

    always_comb
    begin
        scale3  = d2_reg.neg ? NEG_SCALE : {1'b0, POS_SCALE};
        shifted = d2_reg.prod >> d2_reg.shift;
        priority if (d2_reg.zero)
            mag = 17'd0;
        else if (d2_reg.sat)
            mag = scale3;
        else
            mag = shifted[16:0];
        pcm3_next = d2_reg.neg ? 16'(-mag) : mag[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) d1_reg <= d1_next;
        if (en2) d2_reg <= d2_next;
        if (en3)
        begin
            pcm3_reg  <= pcm3_next;
            idx3_reg  <= d2_reg.idx;
            last3_reg <= d2_reg.last;
        end
    end

    assign out_valid = v3_reg;
    assign out_pcm   = pcm3_reg;
    assign out_idx   = idx3_reg;
    assign out_last  = last3_reg;

endmodule

[design/f2p_checker.sv]
// port-level checks for the float to pcm16 converter
module f2p_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] pcm_sample,
    input logic [15:0] write_index
);
    // output word holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pcm_sample) && $stable(write_index))
        else $error("output word changed under stall");

    // an empty output stage never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with output empty");

    // a word accepted reaches the output through the decode, multiply and output registers if not stalled
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("word lost in pipeline");

    // in_ready drops only when the output holds a word and is stalled
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without stall");

endmodule

bind float_to_pcm16_clip_top f2p_checker u_f2p_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pcm_sample  (pcm_sample),
    .write_index (write_index)
);

[dv/tb_float_to_pcm16_clip_top.sv]
// testbench for the float32 to pcm16 sample converter
`timescale 1ns / 1ps

module tb_float_to_pcm16_clip_top;
    import f2p_pkg::*;

    typedef struct packed {
        logic signed [15:0] pcm;
        logic [15:0]        idx;
        logic               last;
    } pcm_word_t;

    class pcm_scoreboard;
        pcm_word_t pending[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // clamp, scale and truncate toward zero on the bit pattern
        function logic signed [15:0] convert(logic [31:0] bits);
            logic        neg;
            logic [7:0]  ex;
            logic [22:0] fr;
            logic [63:0] m;
            logic [63:0] mag;
            logic [63:0] scl;
            int          sh;
            neg = bits[31];
            ex  = bits[30:23];
            fr  = bits[22:0];
            scl = neg ? 64'd32768 : 64'd32767;
            if (ex == 8'hFF && fr != 0)
                return 16'sd0;
            if (ex >= 8'd127)
                mag = scl;
            else
            begin
                if (ex == 8'd0)
                begin
                    m  = {41'd0, fr};
                    ex = 8'd1;
                end
                else
                    m = {40'd0, 1'b1, fr};
                sh = 150 - ex;
                if (sh >= 40)
                    mag = 0;
                else
                    mag = (m * scl) >> sh;
            end
            return neg ? -mag[15:0] : mag[15:0];
        endfunction

        function void note_input(logic [31:0] bits, logic [15:0] idx, logic last);
            pcm_word_t w;
            w.pcm  = convert(bits);
            w.idx  = idx;
            w.last = last;
            pending.push_back(w);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(logic signed [15:0] pcm, logic [15:0] idx, logic last);
            pcm_word_t w;
            if (pending.size() == 0)
            begin
                report("unexpected word", 1, 0);
                return;
            end
            w = pending.pop_front();
            if (pcm !== w.pcm)
                report("pcm_sample", pcm, w.pcm);
            if (idx !== w.idx)
                report("write_index", idx, w.idx);
            if (last !== w.last)
                report("last_out", last, w.last);
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [31:0]        mix_sample;
    logic [15:0]        sample_index;
    logic               last_in_run;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] pcm_sample;
    logic [15:0]        write_index;
    logic               last_out;

    pcm_scoreboard sb;
    int send_idle;
    int recv_stall;
    int hold_off;
    int cycles;

    float_to_pcm16_clip_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mix_sample   (mix_sample),
        .sample_index (sample_index),
        .last_in_run  (last_in_run),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pcm_sample   (pcm_sample),
        .write_index  (write_index),
        .last_out     (last_out)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mix_sample   = '0;
        sample_index = '0;
        last_in_run  = 1'b0;
        out_ready    = 1'b0;
        send_idle    = 0;
        recv_stall   = 0;
        hold_off     = 0;
    end

    // receiver: ready changes at the falling edge, results taken at the rising edge
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(pcm_sample, write_index, last_out);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("float_to_pcm16_clip_top regression: fail");
            $finish;
        end
    end

    initial cycles = 0;

    // offer one word and hold it until taken; valid stays up for a following word
    task send_word(logic [31:0] bits, logic [15:0] idx, logic last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        mix_sample   <= bits;
        sample_index <= idx;
        last_in_run  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(bits, idx, last);
        @(negedge clk);
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    function logic [31:0] rand_float();
        logic [31:0] b;
        b = $urandom();
        case ($urandom_range(5))
            0: b[30:23] = 8'(8'd112 + $urandom_range(15));    // from the pcm lsb up to full scale
            1: b[30:23] = 8'(8'd118 + $urandom_range(9));     // mid range
            2: b[30:23] = 8'(8'd126 + $urandom_range(2));     // near full scale
            3: b[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
            default: ;
        endcase
        return b;
    endfunction

    initial
    begin
        logic [31:0] directed [$];
        int ph;
        int n;
        directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                     32'h3F7F_FFFF, 32'hBF7F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001,
                     32'h807F_FFFF, 32'h4000_0000, 32'hC2C8_0000, 32'h7F7F_FFFF,
                     32'h3800_0000, 32'hB800_0000, 32'h3700_0000, 32'h3F00_0000,
                     32'hBF00_0000, 32'h5555_5555, 32'hAAAA_AAAA};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send_word(directed[i], (i % 2) ? 16'hFFFF : 16'(i), i[0]);
        for (ph = 0; ph < 4; ph++)
        begin
            send_idle  = (ph == 1 || ph == 3) ? 80 : (ph == 3 ? 12 : 0);
            recv_stall = (ph == 2) ? 80 : 0;
            if (ph == 3)
            begin
                send_idle  = 12;
                recv_stall = 12;
            end
            if (ph == 2)
                hold_off = 60;    // long hold-off so the pipe backs up
            for (n = 0; n < 95; n++)
                send_word(rand_float(), 16'($urandom()), 1'($urandom()));
            drain();    // sender waits for every result
        end
        repeat (10) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("float_to_pcm16_clip_top regression: pass");
        else
            $display("float_to_pcm16_clip_top regression: fail");
        $finish;
    end

endmodule
